// ===== hdl/msq_pkg.sv =====
`timescale 1ns / 1ps
package msq_pkg;

  localparam int LEVEL_W = 16;
  localparam int COORD_W = 12;
  localparam int POS_W   = 16;

  typedef enum logic [1:0] {
    CFG_GRID_WIDTH   = 2'd0,
    CFG_GRID_HEIGHT  = 2'd1,
    CFG_BORDER_LEVEL = 2'd2,
    CFG_NONE         = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EDGE_TOP    = 2'd0,
    EDGE_LEFT   = 2'd1,
    EDGE_RIGHT  = 2'd2,
    EDGE_BOTTOM = 2'd3
  } edge_t;

  typedef struct packed {
    logic [COORD_W-1:0]        cell_x;
    logic [COORD_W-1:0]        cell_y;
    logic signed [LEVEL_W-1:0] corner_top_left;
    logic signed [LEVEL_W-1:0] corner_top_right;
    logic signed [LEVEL_W-1:0] corner_bottom_left;
    logic signed [LEVEL_W-1:0] corner_bottom_right;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       case_index;
    logic             land_side;
    logic [1:0]       segment_count;
    logic [1:0]       first_entry_edge;
    logic [1:0]       first_exit_edge;
    logic [POS_W-1:0] first_entry_pos;
    logic [POS_W-1:0] first_exit_pos;
    logic [1:0]       second_entry_edge;
    logic [1:0]       second_exit_edge;
    logic [POS_W-1:0] second_entry_pos;
    logic [POS_W-1:0] second_exit_pos;
  } out_item_t;

  // classified cell handed from front to back
  typedef struct packed {
    logic [3:0]                case_index;
    logic                      land_side;
    logic [1:0]                segment_count;
    logic [1:0]                e0_in;
    logic [1:0]                e0_out;
    logic [1:0]                e1_in;
    logic [1:0]                e1_out;
    logic signed [LEVEL_W-1:0] lv_tl;
    logic signed [LEVEL_W-1:0] lv_tr;
    logic signed [LEVEL_W-1:0] lv_bl;
    logic signed [LEVEL_W-1:0] lv_br;
  } cls_item_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic [1:0] e0_in;
    logic [1:0] e0_out;
    logic [1:0] e1_in;
    logic [1:0] e1_out;
    logic       side;
  } case_info_t;

  function automatic case_info_t case_info(input logic [3:0] idx);
    case_info_t r;
    r = '0;
    case (idx)
      4'd1:  r = '{2'd1, EDGE_LEFT,   EDGE_TOP,    2'd0, 2'd0, 1'b0};
      4'd2:  r = '{2'd1, EDGE_TOP,    EDGE_RIGHT,  2'd0, 2'd0, 1'b1};
      4'd3:  r = '{2'd1, EDGE_LEFT,   EDGE_RIGHT,  2'd0, 2'd0, 1'b0};
      4'd4:  r = '{2'd1, EDGE_BOTTOM, EDGE_LEFT,   2'd0, 2'd0, 1'b0};
      4'd5:  r = '{2'd1, EDGE_BOTTOM, EDGE_TOP,    2'd0, 2'd0, 1'b0};
      4'd6:  r = '{2'd2, EDGE_TOP,    EDGE_RIGHT,  EDGE_BOTTOM, EDGE_LEFT,  1'b1};
      4'd7:  r = '{2'd1, EDGE_BOTTOM, EDGE_RIGHT,  2'd0, 2'd0, 1'b0};
      4'd8:  r = '{2'd1, EDGE_RIGHT,  EDGE_BOTTOM, 2'd0, 2'd0, 1'b1};
      4'd9:  r = '{2'd2, EDGE_LEFT,   EDGE_TOP,    EDGE_RIGHT,  EDGE_BOTTOM, 1'b1};
      4'd10: r = '{2'd1, EDGE_TOP,    EDGE_BOTTOM, 2'd0, 2'd0, 1'b1};
      4'd11: r = '{2'd1, EDGE_LEFT,   EDGE_BOTTOM, 2'd0, 2'd0, 1'b0};
      4'd12: r = '{2'd1, EDGE_RIGHT,  EDGE_LEFT,   2'd0, 2'd0, 1'b0};
      4'd13: r = '{2'd1, EDGE_RIGHT,  EDGE_TOP,    2'd0, 2'd0, 1'b0};
      4'd14: r = '{2'd1, EDGE_TOP,    EDGE_LEFT,   2'd0, 2'd0, 1'b1};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/msq_front.sv =====
`timescale 1ns / 1ps
module msq_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  msq_pkg::in_item_t                  in_item,
  input  logic [msq_pkg::COORD_W-1:0]        grid_width,
  input  logic [msq_pkg::COORD_W-1:0]        grid_height,
  input  logic signed [msq_pkg::LEVEL_W-1:0] border_level,
  output logic                               cls_valid,
  input  logic                               cls_ready,
  output msq_pkg::cls_item_t                 cls_item
);

  logic                      valid_r;
  msq_pkg::cls_item_t        item_r;
  msq_pkg::cls_item_t        item_nxt;
  logic [msq_pkg::COORD_W:0] x0, x1, y0, y1;
  logic                      bx0, bx1, by0, by1;
  logic [3:0]                idx;
  msq_pkg::case_info_t       ci;
  logic signed [msq_pkg::LEVEL_W-1:0] tl, tr, bl, br;

  assign x0  = {1'b0, in_item.cell_x};
  assign y0  = {1'b0, in_item.cell_y};
  assign x1  = x0 + 1'b1;
  assign y1  = y0 + 1'b1;
  assign bx0 = (x0 == '0) || (x0 == {1'b0, grid_width});
  assign bx1 = (x1 == {1'b0, grid_width});
  assign by0 = (y0 == '0) || (y0 == {1'b0, grid_height});
  assign by1 = (y1 == {1'b0, grid_height});

  always_comb begin
    tl  = (bx0 || by0) ? border_level : in_item.corner_top_left;
    tr  = (bx1 || by0) ? border_level : in_item.corner_top_right;
    bl  = (bx0 || by1) ? border_level : in_item.corner_bottom_left;
    br  = (bx1 || by1) ? border_level : in_item.corner_bottom_right;
    idx = {br > 0, bl > 0, tr > 0, tl > 0};
    ci  = msq_pkg::case_info(idx);
    item_nxt = '{idx, ci.side, ci.cnt, ci.e0_in, ci.e0_out, ci.e1_in, ci.e1_out,
                 tl, tr, bl, br};
  end

  assign in_ready  = !valid_r || cls_ready;
  assign cls_valid = valid_r;
  assign cls_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== hdl/msq_fifo.sv =====
`timescale 1ns / 1ps
module msq_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// ===== hdl/msq_div.sv =====
`timescale 1ns / 1ps
module msq_div (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [msq_pkg::LEVEL_W-1:0] a,
  input  logic signed [msq_pkg::LEVEL_W-1:0] b,
  output logic [msq_pkg::POS_W-1:0]          pos
);

  localparam int LW = msq_pkg::LEVEL_W;
  localparam int PW = msq_pkg::POS_W;
  localparam int NW = LW + 1;

  typedef struct packed {
    logic          zero_den;
    logic          zero_out;
    logic [NW-1:0] den;
    logic [NW-1:0] rem;
    logic [PW:0]   q;
  } dstage_t;

  dstage_t st_r [PW+2];

  logic signed [NW-1:0] den_s, a_s;
  logic [NW-1:0]        na, nd;

  always_comb begin
    a_s   = NW'(a);
    den_s = a_s - NW'(b);
    na    = a_s[NW-1] ? NW'(-a_s) : a_s;
    nd    = den_s[NW-1] ? NW'(-den_s) : den_s;
  end

  // one quotient bit per stage; integer part first, then PW fraction bits
  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0].zero_den <= (den_s == '0);
      st_r[0].zero_out <= (a_s == '0) || (a_s[NW-1] != den_s[NW-1]);
      st_r[0].den      <= nd;
      st_r[0].q        <= '0;
      st_r[0].rem      <= na;
    end
  end

  for (genvar i = 0; i < PW + 1; i++) begin : g_stg
    logic [NW:0]   r2;
    logic          ge;
    always_comb begin
      r2 = (i == 0) ? {1'b0, st_r[i].rem} : {st_r[i].rem, 1'b0};
      ge = (r2 >= {1'b0, st_r[i].den});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i+1].zero_den <= st_r[i].zero_den;
        st_r[i+1].zero_out <= st_r[i].zero_out;
        st_r[i+1].den      <= st_r[i].den;
        st_r[i+1].rem      <= ge ? NW'(r2 - {1'b0, st_r[i].den}) : NW'(r2);
        st_r[i+1].q        <= {st_r[i].q[PW-1:0], ge};
      end
    end
  end

  always_comb begin
    if (st_r[PW+1].zero_den) begin
      pos = PW'(1) << (PW - 1);
    end else if (st_r[PW+1].zero_out) begin
      pos = '0;
    end else if (st_r[PW+1].q[PW]) begin
      pos = '1;
    end else begin
      pos = st_r[PW+1].q[PW-1:0];
    end
  end

endmodule

// ===== hdl/msq_back.sv =====
`timescale 1ns / 1ps
module msq_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cls_valid,
  output logic                cls_ready,
  input  msq_pkg::cls_item_t  cls_item,
  output logic                out_empty,
  input  logic                out_pop,
  output msq_pkg::out_item_t  out_item
);

  localparam int DEPTH = msq_pkg::POS_W + 2;
  localparam int OUT_W = $bits(msq_pkg::out_item_t);

  typedef struct packed {
    logic [3:0] case_index;
    logic       land_side;
    logic [1:0] cnt;
    logic [1:0] e0_in;
    logic [1:0] e0_out;
    logic [1:0] e1_in;
    logic [1:0] e1_out;
  } tag_t;

  tag_t tag_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic en;
  logic signed [msq_pkg::LEVEL_W-1:0] a0, b0, a1, b1, a2, b2, a3, b3;
  logic [msq_pkg::POS_W-1:0] p0, p1, p2, p3;
  msq_pkg::out_item_t res;
  logic ob_ready, ob_valid;
  logic [OUT_W-1:0] ob_data;

  function automatic logic signed [2*msq_pkg::LEVEL_W-1:0] edge_pair(
    input logic [1:0] e, input msq_pkg::cls_item_t c);
    logic signed [2*msq_pkg::LEVEL_W-1:0] r;
    r = '0;
    case (e)
      msq_pkg::EDGE_TOP:    r = {c.lv_tl, c.lv_tr};
      msq_pkg::EDGE_LEFT:   r = {c.lv_tl, c.lv_bl};
      msq_pkg::EDGE_RIGHT:  r = {c.lv_tr, c.lv_br};
      msq_pkg::EDGE_BOTTOM: r = {c.lv_bl, c.lv_br};
      default:              r = '0;
    endcase
    return r;
  endfunction

  // pipeline advances only when the last stage can drain into the output queue
  assign en        = ob_ready || !vld_r[DEPTH-1];
  assign cls_ready = en;

  assign {a0, b0} = edge_pair(cls_item.e0_in, cls_item);
  assign {a1, b1} = edge_pair(cls_item.e0_out, cls_item);
  assign {a2, b2} = edge_pair(cls_item.e1_in, cls_item);
  assign {a3, b3} = edge_pair(cls_item.e1_out, cls_item);

  msq_div u_d0 (.clk, .en, .a(a0), .b(b0), .pos(p0));
  msq_div u_d1 (.clk, .en, .a(a1), .b(b1), .pos(p1));
  msq_div u_d2 (.clk, .en, .a(a2), .b(b2), .pos(p2));
  msq_div u_d3 (.clk, .en, .a(a3), .b(b3), .pos(p3));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], cls_valid};
    end
    if (en) begin
      tag_r[0] <= '{cls_item.case_index, cls_item.land_side, cls_item.segment_count,
                    cls_item.e0_in, cls_item.e0_out, cls_item.e1_in, cls_item.e1_out};
      for (int i = 1; i < DEPTH; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
    end
  end

  always_comb begin
    res = '0;
    res.case_index    = tag_r[DEPTH-1].case_index;
    res.land_side     = tag_r[DEPTH-1].land_side;
    res.segment_count = tag_r[DEPTH-1].cnt;
    if (tag_r[DEPTH-1].cnt != 2'd0) begin
      res.first_entry_edge = tag_r[DEPTH-1].e0_in;
      res.first_exit_edge  = tag_r[DEPTH-1].e0_out;
      res.first_entry_pos  = p0;
      res.first_exit_pos   = p1;
    end
    if (tag_r[DEPTH-1].cnt == 2'd2) begin
      res.second_entry_edge = tag_r[DEPTH-1].e1_in;
      res.second_exit_edge  = tag_r[DEPTH-1].e1_out;
      res.second_entry_pos  = p2;
      res.second_exit_pos   = p3;
    end
  end

  msq_fifo #(.WIDTH(OUT_W)) u_obuf (
    .clk, .rst_n,
    .wr_valid(vld_r[DEPTH-1]), .wr_ready(ob_ready), .wr_data(res),
    .rd_valid(ob_valid), .rd_ready(out_pop), .rd_data(ob_data)
  );

  assign out_empty = !ob_valid;
  assign out_item  = ob_data;

endmodule

// ===== hdl/marching_squares_cell_classifier.sv =====
// Result path: front register, mid queue, 18 divider stages, output queue.
// Throughput: one cell per cycle unless stalled, set by the bit-per-stage restoring
// divider pipeline. Output queue holds 2 results; the divider pipeline stalls while
// it is full and a result waits at the last divider stage. Reset: synchronous
// active-low rst_n empties all queues and pipelines and loads grid_width = 64, grid_height = 64, border_level = -16.
`timescale 1ns / 1ps
module marching_squares_cell_classifier (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  msq_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output msq_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [msq_pkg::COORD_W-1:0]        grid_width_r, grid_height_r;
  logic signed [msq_pkg::LEVEL_W-1:0] border_level_r;
  logic                               in_ready;
  logic                               f_valid, f_ready, q_valid, q_ready;
  msq_pkg::cls_item_t                 f_item, q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r   <= msq_pkg::COORD_W'(64);
      grid_height_r  <= msq_pkg::COORD_W'(64);
      border_level_r <= -msq_pkg::LEVEL_W'(16);
    end else if (cfg_valid) begin
      case (msq_pkg::cfg_idx_t'(cfg_index))
        msq_pkg::CFG_GRID_WIDTH:   grid_width_r   <= cfg_data[msq_pkg::COORD_W-1:0];
        msq_pkg::CFG_GRID_HEIGHT:  grid_height_r  <= cfg_data[msq_pkg::COORD_W-1:0];
        msq_pkg::CFG_BORDER_LEVEL: border_level_r <= cfg_data[msq_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_full = !in_ready;

  msq_front u_front (
    .clk, .rst_n,
    .in_valid(in_push), .in_ready, .in_item(in_data),
    .grid_width(grid_width_r), .grid_height(grid_height_r),
    .border_level(border_level_r),
    .cls_valid(f_valid), .cls_ready(f_ready), .cls_item(f_item)
  );

  msq_fifo #(.WIDTH($bits(msq_pkg::cls_item_t))) u_mid (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_item)
  );

  msq_back u_back (
    .clk, .rst_n,
    .cls_valid(q_valid), .cls_ready(q_ready), .cls_item(q_item),
    .out_empty, .out_pop, .out_item(out_data)
  );

endmodule

// ===== hdl/msq_checker.sv =====
`timescale 1ns / 1ps
module msq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input msq_pkg::out_item_t out_data
);

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full)) else $error("queues not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_data))
    else $error("waiting transaction changed");

  a_seg_count: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.segment_count != 2'd3))
    else $error("bad segment count");

  a_saddle: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.segment_count == 2'd2) |->
      (out_data.case_index == 4'd6 || out_data.case_index == 4'd9))
    else $error("two segments outside saddle case");

  a_no_seg: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_data.case_index == 4'd0 || out_data.case_index == 4'd15)) |->
      (out_data.segment_count == 2'd0))
    else $error("segment in uniform cell");

endmodule

bind marching_squares_cell_classifier msq_checker u_msq_checker (
  .clk, .rst_n, .in_full, .out_empty, .out_pop, .out_data
);
